// ===== hw/rtl/necd_pkg.sv =====
`timescale 1ns / 1ps
package necd_pkg;

  localparam int unsigned DurW            = 15;
  localparam int unsigned FieldW          = 16;
  localparam int unsigned CountW          = 6;
  localparam int unsigned FramePairs      = 34;
  localparam int unsigned RepeatPairs     = 2;
  localparam int unsigned MarginW         = 12;
  localparam int unsigned DecodeMarginDef = 200;
  localparam int unsigned QueueDepthDef   = 2;
  localparam int unsigned RegCount        = 8;
  localparam int unsigned ApbAddrW        = 5;
  localparam int unsigned ApbDataW        = 32;

  typedef logic [DurW-1:0] dur_t;

  typedef enum logic [2:0] {
    StFrameOk   = 3'd0,
    StRepeatOk  = 3'd1,
    StFrameErr  = 3'd2,
    StRepeatErr = 3'd3,
    StWrongLen  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    RegLeaderMark  = 3'd0,
    RegLeaderSpace = 3'd1,
    RegZeroMark    = 3'd2,
    RegZeroSpace   = 3'd3,
    RegOneMark     = 3'd4,
    RegOneSpace    = 3'd5,
    RegRepeatMark  = 3'd6,
    RegRepeatSpace = 3'd7
  } reg_idx_e;

  localparam dur_t RegReset [RegCount] = '{
    15'd9000, 15'd4500, 15'd560, 15'd560, 15'd560, 15'd1690, 15'd9000, 15'd2250
  };

  typedef struct packed {
    dur_t leader_mark;
    dur_t leader_space;
    dur_t zero_mark;
    dur_t zero_space;
    dur_t one_mark;
    dur_t one_space;
    dur_t repeat_mark;
    dur_t repeat_space;
  } cfg_t;

  // timing class of one pulse pair, as handed from front to back
  typedef struct packed {
    logic leader_ok;
    logic repeat_ok;
    logic one_ok;
    logic zero_ok;
    logic last;
  } pair_class_t;

endpackage

// ===== hw/rtl/necd_if.sv =====
`timescale 1ns / 1ps
interface necd_pair_if;
  import necd_pkg::*;

  logic valid;
  logic ready;
  dur_t mark_duration;
  dur_t space_duration;
  logic last_in_burst;

  modport source (output valid, output mark_duration, output space_duration,
                  output last_in_burst, input ready);
  modport sink (input valid, input mark_duration, input space_duration,
                input last_in_burst, output ready);
endinterface

interface necd_result_if;
  import necd_pkg::*;

  logic              valid;
  logic              ready;
  status_e           status;
  logic [FieldW-1:0] address;
  logic [FieldW-1:0] command_word;

  modport source (output valid, output status, output address, output command_word,
                  input ready);
  modport sink (input valid, input status, input address, input command_word,
                output ready);
endinterface

// ===== hw/rtl/necd_front.sv =====
`timescale 1ns / 1ps
module necd_front #(
  parameter int unsigned DECODE_MARGIN = necd_pkg::DecodeMarginDef
) (
  input  necd_pkg::cfg_t        cfg_i,
  necd_pair_if.sink             pair_i,
  output necd_pkg::pair_class_t cls_o,
  output logic                  cls_valid_o,
  input  logic                  cls_ready_i
);
  import necd_pkg::*;

  localparam int unsigned SumW = DurW + 1;
  localparam logic [SumW-1:0] Margin = SumW'(DECODE_MARGIN);

  // s - m < d < s + m, rearranged so that nothing goes below zero
  function automatic logic near_spec(dur_t d, dur_t s);
    logic [SumW-1:0] d_ext;
    logic [SumW-1:0] s_ext;
    d_ext = {1'b0, d};
    s_ext = {1'b0, s};
    return ((d_ext + Margin) > s_ext) && (d_ext < (s_ext + Margin));
  endfunction

  assign pair_i.ready = cls_ready_i;
  assign cls_valid_o  = pair_i.valid;

  always_comb begin
    cls_o.leader_ok = near_spec(pair_i.mark_duration, cfg_i.leader_mark) &&
                      near_spec(pair_i.space_duration, cfg_i.leader_space);
    cls_o.repeat_ok = near_spec(pair_i.mark_duration, cfg_i.repeat_mark) &&
                      near_spec(pair_i.space_duration, cfg_i.repeat_space);
    cls_o.one_ok    = near_spec(pair_i.mark_duration, cfg_i.one_mark) &&
                      near_spec(pair_i.space_duration, cfg_i.one_space);
    cls_o.zero_ok   = near_spec(pair_i.mark_duration, cfg_i.zero_mark) &&
                      near_spec(pair_i.space_duration, cfg_i.zero_space);
    cls_o.last      = pair_i.last_in_burst;
  end

endmodule

// ===== hw/rtl/necd_queue.sv =====
`timescale 1ns / 1ps
module necd_queue #(
  parameter int unsigned DEPTH = necd_pkg::QueueDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  necd_pkg::pair_class_t push_data_i,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  output necd_pkg::pair_class_t pop_data_o,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i
);
  import necd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  pair_class_t     mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/necd_back.sv =====
`timescale 1ns / 1ps
module necd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  necd_pkg::pair_class_t cls_i,
  input  logic                  cls_valid_i,
  output logic                  cls_ready_o,
  necd_result_if.source         res_o
);
  import necd_pkg::*;

  localparam int unsigned PosW = $clog2(2 * FieldW);
  localparam int unsigned BitW = $clog2(FieldW);
  localparam logic [CountW-1:0] CntFrame  = CountW'(FramePairs);
  localparam logic [CountW-1:0] CntRepeat = CountW'(RepeatPairs);
  localparam logic [CountW-1:0] CntBits   = CountW'(2 * FieldW);
  localparam logic [CountW-1:0] CntSat    = CountW'(FramePairs + 1);

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [FieldW-1:0] addr_sh_q, addr_sh_d;
  logic [FieldW-1:0] cmd_sh_q, cmd_sh_d;
  logic              frame_good_q, frame_good_d;
  logic              repeat_good_q, repeat_good_d;
  logic              res_valid_q;
  status_e           status_q, status_d;
  logic [FieldW-1:0] addr_q, addr_d;
  logic [FieldW-1:0] cmd_q, cmd_d;
  logic              take;
  logic [PosW-1:0]   pos;

  assign cls_ready_o = !res_valid_q || res_o.ready;
  assign take        = cls_valid_i && cls_ready_o;
  assign pos         = PosW'(cnt_q - 1'b1);

  always_comb begin
    cnt_d         = cnt_q;
    addr_sh_d     = addr_sh_q;
    cmd_sh_d      = cmd_sh_q;
    frame_good_d  = frame_good_q;
    repeat_good_d = repeat_good_q;
    status_d      = StWrongLen;
    addr_d        = '0;
    cmd_d         = '0;

    if (cnt_q == '0) begin
      frame_good_d  = cls_i.leader_ok;
      repeat_good_d = cls_i.repeat_ok;
    end else if (cnt_q <= CntBits && frame_good_q) begin
      // one is tried first, then zero
      if (cls_i.one_ok) begin
        if (!pos[PosW-1]) begin
          addr_sh_d[pos[BitW-1:0]] = 1'b1;
        end else begin
          cmd_sh_d[pos[BitW-1:0]] = 1'b1;
        end
      end else if (!cls_i.zero_ok) begin
        frame_good_d = 1'b0;
      end
    end

    if (cnt_q < CntSat) begin
      cnt_d = cnt_q + 1'b1;
    end

    if (cnt_d == CntFrame) begin
      if (frame_good_d) begin
        status_d = StFrameOk;
        addr_d   = addr_sh_d;
        cmd_d    = cmd_sh_d;
      end else begin
        status_d = StFrameErr;
      end
    end else if (cnt_d == CntRepeat) begin
      status_d = repeat_good_d ? StRepeatOk : StRepeatErr;
    end

    // end of burst: back to the idle values
    if (cls_i.last) begin
      cnt_d         = '0;
      addr_sh_d     = '0;
      cmd_sh_d      = '0;
      frame_good_d  = 1'b1;
      repeat_good_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      addr_sh_q     <= '0;
      cmd_sh_q      <= '0;
      frame_good_q  <= 1'b1;
      repeat_good_q <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      if (take) begin
        cnt_q         <= cnt_d;
        addr_sh_q     <= addr_sh_d;
        cmd_sh_q      <= cmd_sh_d;
        frame_good_q  <= frame_good_d;
        repeat_good_q <= repeat_good_d;
      end
      if (take && cls_i.last) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cls_i.last) begin
      status_q <= status_d;
      addr_q   <= addr_d;
      cmd_q    <= cmd_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.status       = status_q;
  assign res_o.address      = addr_q;
  assign res_o.command_word = cmd_q;

endmodule

// ===== hw/rtl/nec_ir_pulse_frame_decoder.sv =====
`timescale 1ns / 1ps
// the closing pair of a burst passes through the classify queue before the back part registers its result
// throughput: one pulse pair per cycle while no taken result is held up by res_o.ready, set by the back part
// the classify queue lets the input side run on while a result waits to be taken
// reset: asynchronous, active low; timing registers return to their defaults and the
// burst state and queue are cleared, with no sweep needed
module nec_ir_pulse_frame_decoder #(
  parameter int unsigned DECODE_MARGIN = necd_pkg::DecodeMarginDef,
  parameter int unsigned QUEUE_DEPTH   = necd_pkg::QueueDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [necd_pkg::ApbAddrW-1:0]   paddr,
  input  logic [necd_pkg::ApbDataW-1:0]   pwdata,
  output logic [necd_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  necd_pair_if.sink                       pair_i,
  necd_result_if.source                   res_o
);
  import necd_pkg::*;

  localparam int unsigned IdxW = $clog2(RegCount);

  dur_t          cfg_q [RegCount];
  cfg_t          cfg;
  logic [IdxW-1:0] reg_idx;
  pair_class_t   cls_push, cls_pop;
  logic          push_valid, push_ready, pop_valid, pop_ready;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:2];
  assign prdata  = {{(ApbDataW - DurW){1'b0}}, cfg_q[reg_idx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) begin
        cfg_q[i] <= RegReset[i];
      end
    end else if (psel && penable && pwrite && pready) begin
      cfg_q[reg_idx] <= pwdata[DurW-1:0];
    end
  end

  always_comb begin
    cfg.leader_mark  = cfg_q[RegLeaderMark];
    cfg.leader_space = cfg_q[RegLeaderSpace];
    cfg.zero_mark    = cfg_q[RegZeroMark];
    cfg.zero_space   = cfg_q[RegZeroSpace];
    cfg.one_mark     = cfg_q[RegOneMark];
    cfg.one_space    = cfg_q[RegOneSpace];
    cfg.repeat_mark  = cfg_q[RegRepeatMark];
    cfg.repeat_space = cfg_q[RegRepeatSpace];
  end

  necd_front #(
    .DECODE_MARGIN(DECODE_MARGIN)
  ) u_front (
    .cfg_i       (cfg),
    .pair_i      (pair_i),
    .cls_o       (cls_push),
    .cls_valid_o (push_valid),
    .cls_ready_i (push_ready)
  );

  necd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (cls_push),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (cls_pop),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  necd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (cls_pop),
    .cls_valid_i (pop_valid),
    .cls_ready_o (pop_ready),
    .res_o       (res_o)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import necd_pkg::*;

  localparam int Margin      = DecodeMarginDef;
  localparam int DurMax      = 2 ** DurW - 1;
  localparam int DrainCycles = 8;
  localparam int LongStall   = 300;
  localparam int CycleLimit  = 200_000;

  typedef enum int {
    JitNear,
    JitEdgeIn,
    JitEdgeOut,
    JitAny
  } jitter_e;

  typedef struct packed {
    dur_t mark;
    dur_t space;
    logic last;
  } ir_pair_t;

  typedef struct packed {
    status_e           status;
    logic [FieldW-1:0] address;
    logic [FieldW-1:0] command_word;
  } decode_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  necd_pair_if   pair_bus ();
  necd_result_if res_bus ();

  nec_ir_pulse_frame_decoder #(
    .DECODE_MARGIN(Margin)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .pair_i (pair_bus),
    .res_o  (res_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // decoder state as seen from outside
  dur_t              timing [RegCount];
  int                pairs_seen;
  logic [FieldW-1:0] addr_bits;
  logic [FieldW-1:0] cmd_bits;
  logic              frame_intact;
  logic              repeat_intact;

  decode_result_t    decodes_due [$];
  decode_result_t    want;
  ir_pair_t          burst_q [$];

  int fail_count  = 0;
  int cycle_count = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int stall_for    = 0;

  function automatic void clear_burst();
    pairs_seen    = 0;
    addr_bits     = '0;
    cmd_bits      = '0;
    frame_intact  = 1'b1;
    repeat_intact = 1'b0;
  endfunction

  function automatic bit in_window(dur_t d, dur_t spec);
    int dv;
    int sv;
    dv = d;
    sv = spec;
    return (dv < sv + Margin) && (dv > sv - Margin);
  endfunction

  function automatic bit pair_fits(dur_t m, dur_t s, reg_idx_e mark_reg);
    return in_window(m, timing[mark_reg]) && in_window(s, timing[int'(mark_reg) + 1]);
  endfunction

  // advance the burst by one accepted item, queue a result on the closing pair
  function automatic void decode_pair(ir_pair_t p);
    decode_result_t res;
    int             pos;
    logic           bit_val;
    if (pairs_seen == 0) begin
      frame_intact  = pair_fits(p.mark, p.space, RegLeaderMark);
      repeat_intact = pair_fits(p.mark, p.space, RegRepeatMark);
    end else if (pairs_seen <= 2 * FieldW) begin
      if (frame_intact) begin
        bit_val = 1'b0;
        if (pair_fits(p.mark, p.space, RegOneMark)) begin
          bit_val = 1'b1;
        end else if (!pair_fits(p.mark, p.space, RegZeroMark)) begin
          frame_intact = 1'b0;
        end
        if (frame_intact && bit_val) begin
          pos = pairs_seen - 1;
          if (pos < FieldW) addr_bits[pos] = 1'b1;
          else cmd_bits[pos - FieldW] = 1'b1;
        end
      end
    end
    if (pairs_seen < FramePairs + 1) pairs_seen++;
    if (p.last) begin
      res.address      = '0;
      res.command_word = '0;
      if (pairs_seen == FramePairs) begin
        if (frame_intact) begin
          res.status       = StFrameOk;
          res.address      = addr_bits;
          res.command_word = cmd_bits;
        end else begin
          res.status = StFrameErr;
        end
      end else if (pairs_seen == RepeatPairs) begin
        res.status = repeat_intact ? StRepeatOk : StRepeatErr;
      end else begin
        res.status = StWrongLen;
      end
      decodes_due.push_back(res);
      clear_burst();
    end
  endfunction

  function automatic dur_t pick_dur(dur_t spec, jitter_e how);
    int v;
    case (how)
      JitNear: begin
        v = int'(spec) + int'($urandom_range(0, 2 * (Margin - 1))) - (Margin - 1);
      end
      JitEdgeIn: begin
        v = $urandom_range(0, 1) ? int'(spec) + Margin - 1 : int'(spec) - Margin + 1;
      end
      JitEdgeOut: begin
        v = $urandom_range(0, 1) ? int'(spec) + Margin : int'(spec) - Margin;
      end
      default: begin
        v = int'($urandom_range(0, DurMax));
      end
    endcase
    if (v < 0) v = 0;
    else if (v > DurMax) v = DurMax;
    return dur_t'(v);
  endfunction

  function automatic void add_pair(int m, int s, bit last);
    ir_pair_t p;
    p.mark  = dur_t'(m);
    p.space = dur_t'(s);
    p.last  = last;
    burst_q.push_back(p);
  endfunction

  // leader, 32 bit pairs, then trailing pairs; bad_at spoils one pair
  function automatic void add_frame(logic [FieldW-1:0] adr, logic [FieldW-1:0] cmd,
                                    int n_pairs, int bad_at, int edge_pct);
    ir_pair_t p;
    reg_idx_e base;
    jitter_e  jit;
    int       i;
    base = RegLeaderMark;
    for (i = 0; i < n_pairs; i++) begin
      jit = ($urandom_range(0, 99) < edge_pct) ? JitEdgeIn : JitNear;
      if (i == 0) begin
        base = RegLeaderMark;
      end else if (i <= 2 * FieldW) begin
        base = ((i <= FieldW) ? adr[i-1] : cmd[i-1-FieldW]) ? RegOneMark : RegZeroMark;
      end
      if (i > 2 * FieldW) begin
        p.mark  = pick_dur('0, JitAny);
        p.space = pick_dur('0, JitAny);
      end else begin
        p.mark  = pick_dur(timing[base], jit);
        p.space = pick_dur(timing[int'(base) + 1], jit);
      end
      if (i == bad_at) begin
        if ($urandom_range(0, 1)) p.mark = pick_dur(timing[base], JitEdgeOut);
        else p.space = pick_dur(timing[int'(base) + 1], JitEdgeOut);
      end
      p.last = (i == n_pairs - 1);
      burst_q.push_back(p);
    end
  endfunction

  function automatic void add_repeat(bit spoil);
    dur_t m;
    dur_t s;
    m = pick_dur(timing[RegRepeatMark], JitNear);
    s = pick_dur(timing[RegRepeatSpace], JitNear);
    if (spoil) begin
      if ($urandom_range(0, 1)) m = pick_dur(timing[RegRepeatMark], JitEdgeOut);
      else s = pick_dur(timing[RegRepeatSpace], JitEdgeOut);
    end
    add_pair(m, s, 1'b0);
    // second pair of a repeat code is never checked
    add_pair(pick_dur('0, JitAny), pick_dur('0, JitAny), 1'b1);
  endfunction

  function automatic void add_noise(int n);
    int i;
    for (i = 0; i < n; i++) add_pair(pick_dur('0, JitAny), pick_dur('0, JitAny), i == n - 1);
  endfunction

  task automatic send_pair(ir_pair_t p);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      pair_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    pair_bus.valid          <= 1'b1;
    pair_bus.mark_duration  <= p.mark;
    pair_bus.space_duration <= p.space;
    pair_bus.last_in_burst  <= p.last;
    do @(posedge clk_i); while (pair_bus.ready !== 1'b1);
    decode_pair(p);
    @(negedge clk_i);
  endtask

  task automatic send_burst();
    foreach (burst_q[i]) send_pair(burst_q[i]);
    burst_q.delete();
  endtask

  task automatic wait_for_quiet();
    pair_bus.valid <= 1'b0;
    while (decodes_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_idling(int snd, int rcv);
    wait_for_quiet();
    @(posedge clk_i);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    @(negedge clk_i);
  endtask

  task automatic check_timing_reg(reg_idx_e idx);
    logic [ApbDataW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    if (rd !== ApbDataW'(timing[idx])) begin
      $display("%0t register %s readback: expected %h got %h", $time, idx.name(),
               ApbDataW'(timing[idx]), rd);
      fail_count++;
    end
  endtask

  task automatic write_timing(reg_idx_e idx, dur_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ApbDataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    timing[idx] = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    check_timing_reg(idx);
  endtask

  task automatic load_timing(input dur_t vals [RegCount]);
    wait_for_quiet();
    for (int i = 0; i < RegCount; i++) write_timing(reg_idx_e'(i), vals[i]);
  endtask

  task automatic test_register_reset();
    for (int i = 0; i < RegCount; i++) check_timing_reg(reg_idx_e'(i));
  endtask

  task automatic test_short_bursts();
    int rm;
    int rs;
    rm = timing[RegRepeatMark];
    rs = timing[RegRepeatSpace];
    add_pair(0, 0, 1'b1);
    add_pair(DurMax, DurMax, 1'b1);
    add_pair(rm, rs, 1'b0);
    add_pair(0, DurMax, 1'b1);
    // repeat pair just inside the window on both sides
    add_pair(rm + Margin - 1, rs - Margin + 1, 1'b0);
    add_pair(DurMax, 0, 1'b1);
    add_pair(rm - Margin + 1, rs + Margin - 1, 1'b0);
    add_pair(DurMax, DurMax, 1'b1);
    // just outside on mark, then on space
    add_pair(rm + Margin, rs, 1'b0);
    add_pair(rm, rs, 1'b1);
    add_pair(rm, rs - Margin, 1'b0);
    add_pair(rm, rs, 1'b1);
    add_pair(rm, rs, 1'b0);
    add_pair(rm, rs, 1'b0);
    add_pair(rm, rs, 1'b1);
    // leader followed by one bit is a failed repeat
    add_pair(timing[RegLeaderMark], timing[RegLeaderSpace], 1'b0);
    add_pair(timing[RegOneMark], timing[RegOneSpace], 1'b1);
    send_burst();
  endtask

  task automatic test_random_bursts(int n_items);
    int sent;
    int roll;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        add_frame(FieldW'($urandom), FieldW'($urandom), FramePairs, -1, 15);
      end else if (roll < 45) begin
        add_frame(FieldW'($urandom), FieldW'($urandom), FramePairs,
                  $urandom_range(0, FramePairs - 1), 15);
      end else if (roll < 70) begin
        add_repeat(1'b0);
      end else if (roll < 78) begin
        add_repeat(1'b1);
      end else if (roll < 88) begin
        add_frame(FieldW'($urandom), FieldW'($urandom),
                  $urandom_range(0, 1) ? $urandom_range(FramePairs - 1, FramePairs + 6)
                                       : $urandom_range(1, FramePairs), -1, 15);
      end else begin
        add_noise($urandom_range(1, 4));
      end
      sent += burst_q.size();
      send_burst();
    end
  endtask

  task automatic test_timing_extremes();
    dur_t vals [RegCount];
    vals = '{default: '0};
    load_timing(vals);
    test_random_bursts(100);
    vals = '{default: dur_t'(DurMax)};
    load_timing(vals);
    test_random_bursts(100);
  endtask

  task automatic test_random_timing();
    dur_t vals [RegCount];
    foreach (vals[i]) vals[i] = dur_t'($urandom_range(0, DurMax));
    load_timing(vals);
    test_random_bursts(300);
  endtask

  task automatic test_scaled_timing();
    dur_t vals [RegCount];
    foreach (vals[i]) vals[i] = RegReset[i] >> 1;
    load_timing(vals);
    test_random_bursts(300);
  endtask

  // results pile up behind a stalled receiver until the input side backs off
  task automatic test_result_backpressure();
    int i;
    wait_for_quiet();
    @(posedge clk_i);
    stall_for = LongStall;
    @(negedge clk_i);
    for (i = 0; i < 30; i++) begin
      if (i % 3 == 0) add_repeat(1'b0);
      else add_noise(1);
    end
    send_burst();
  endtask

  always @(negedge clk_i) begin
    if (stall_for > 0) begin
      res_bus.ready <= 1'b0;
      stall_for--;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      if (decodes_due.size() == 0) begin
        $display("%0t unexpected result: status %0d address %h command %h", $time,
                 res_bus.status, res_bus.address, res_bus.command_word);
        fail_count++;
      end else begin
        want = decodes_due.pop_front();
        if (res_bus.status !== want.status) begin
          $display("%0t status: expected %0d got %0d", $time, want.status, res_bus.status);
          fail_count++;
        end
        if (res_bus.address !== want.address) begin
          $display("%0t address: expected %h got %h", $time, want.address, res_bus.address);
          fail_count++;
        end
        if (res_bus.command_word !== want.command_word) begin
          $display("%0t command: expected %h got %h", $time, want.command_word,
                   res_bus.command_word);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni                  = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    pair_bus.valid          = 1'b0;
    pair_bus.mark_duration  = '0;
    pair_bus.space_duration = '0;
    pair_bus.last_in_burst  = 1'b0;
    res_bus.ready           = 1'b0;
    timing                  = RegReset;
    clear_burst();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_idling(31, 73);
    test_register_reset();
    test_short_bursts();
    test_random_bursts(400);
    test_timing_extremes();
    set_idling(73, 31);
    test_random_timing();
    set_idling(0, 0);
    test_scaled_timing();
    test_result_backpressure();

    wait_for_quiet();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/necd_pkg.sv
hw/rtl/necd_if.sv
hw/rtl/necd_front.sv
hw/rtl/necd_queue.sv
hw/rtl/necd_back.sv
hw/rtl/nec_ir_pulse_frame_decoder.sv
test/tb_top.sv
